>>> rtl/core/kslq_pkg.sv
// kslq_pkg: shared widths, operation codes and status codes of the keyed
// stack/queue list. No dependencies; imported by the top level and the testbench.
`default_nettype none

package kslq_pkg;

    // default number of entries
    localparam int DEPTH_DEF = 64;

    // field widths
    localparam int OP_W     = 3;
    localparam int KEY_W    = 32;
    localparam int PAY_W    = 32;
    localparam int STATUS_W = 2;
    localparam int ENTRY_W  = KEY_W + PAY_W;

    // input transfer: op, key, payload packed from bit 0, padded to bytes
    localparam int S_FIELDS_W = OP_W + KEY_W + PAY_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;

    // operation codes
    localparam logic [OP_W-1:0] OP_PUSH_BACK = 3'd0;
    localparam logic [OP_W-1:0] OP_POP_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT = 3'd2;
    localparam logic [OP_W-1:0] OP_DELETE    = 3'd3;
    localparam logic [OP_W-1:0] OP_SEARCH    = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR     = 3'd5;
    localparam logic [OP_W-1:0] OP_INSERT    = 3'd6;

    // status codes
    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY     = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd3;

endpackage

`default_nettype wire

>>> rtl/core/kslq_ram.sv
// kslq_ram: generic simple dual-port RAM, one write and one registered read
// port. No dependencies.
`default_nettype none

module kslq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/keyed_stack_queue_list_unit.sv
// keyed_stack_queue_list_unit: top level of the keyed stack/queue list.
// Depends on kslq_pkg and kslq_ram.
//
// s_ channel: one request per transfer (op, key, payload in s_tdata).
// m_ channel: exactly one result per request (status, key_out, payload_out,
// count in m_tdata), in request order. Entries live in a circular store in
// one RAM (key and payload side by side); a sequencer reads, compares and
// moves entries one per cycle through its single read and write port.
// A search compares one stored entry per cycle, from the front; delete and
// sorted insert scan to the hit, then move one entry per cycle over the
// rest of the list. A new request is taken only after the previous one
// has produced its result.
// Reset (aresetn low, synchronous) empties the list and drops any result.
// When the receiver stalls, one finished result waits in the output
// register; the next request is still taken and runs, then holds in the
// sequencer until the output register frees.
`default_nettype none

module keyed_stack_queue_list_unit #(
    parameter int DEPTH = kslq_pkg::DEPTH_DEF,
    localparam int CW = $clog2(DEPTH + 1),
    localparam int M_TDATA_W = ((kslq_pkg::STATUS_W + kslq_pkg::KEY_W
                                 + kslq_pkg::PAY_W + CW + 7) / 8) * 8
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // [2:0] op, [34:3] key, [66:35] payload
    input  wire logic [kslq_pkg::S_TDATA_W-1:0]  s_tdata,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // [1:0] status, [33:2] key_out, [65:34] payload_out, [65+CW:66] count
    output logic      [M_TDATA_W-1:0]            m_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready
);

    import kslq_pkg::*;

    localparam int AW = $clog2(DEPTH);

    // sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_START = 3'd1;
    localparam logic [2:0] ST_POP   = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_SHIFT = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [OP_W-1:0]     op_reg, op_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [PAY_W-1:0]    pay_reg, pay_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [AW-1:0]       front_reg, front_next;
    logic [CW-1:0]       rd_pos_reg, rd_pos_next;
    logic                cmp_valid_reg, cmp_valid_next;
    logic [CW-1:0]       cmp_pos_reg, cmp_pos_next;
    logic [CW-1:0]       left_reg, left_next;
    logic                wr_pend_reg, wr_pend_next;
    logic [CW-1:0]       wr_pos_reg, wr_pos_next;
    logic [CW-1:0]       ins_pos_reg, ins_pos_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [KEY_W-1:0]    res_key_reg, res_key_next;
    logic [PAY_W-1:0]    res_pay_reg, res_pay_next;

    logic                m_tvalid_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic [KEY_W-1:0]    m_key_reg;
    logic [PAY_W-1:0]    m_pay_reg;
    logic [CW-1:0]       m_count_reg;

    logic                ram_wr_en;
    logic [AW-1:0]       ram_wr_addr;
    logic [ENTRY_W-1:0]  ram_wr_data;
    logic                ram_rd_en;
    logic [AW-1:0]       ram_rd_addr;
    logic [ENTRY_W-1:0]  ram_rd_data;

    logic [KEY_W-1:0]    rd_key;
    logic [PAY_W-1:0]    rd_pay;
    logic                full;
    logic                empty;
    logic                hit;
    logic                out_free;
    logic                s_xfer;

    // circular store slot of a list position
    function automatic logic [AW-1:0] slot_of(input logic [CW-1:0] pos,
                                              input logic [AW-1:0] front);
        logic [CW:0] sum;
        sum = {1'b0, pos} + (CW+1)'(front);
        if (sum >= (CW+1)'(DEPTH)) begin
            sum = sum - (CW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    kslq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign rd_key   = ram_rd_data[KEY_W-1:0];
    assign rd_pay   = ram_rd_data[ENTRY_W-1:KEY_W];
    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign s_xfer   = s_tvalid && s_tready;

    // compare of the entry read in the previous scan cycle
    always_comb begin
        if (op_reg == OP_INSERT) begin
            hit = cmp_valid_reg && ($signed(key_reg) <= $signed(rd_key));
        end else begin
            hit = cmp_valid_reg && (key_reg == rd_key);
        end
    end

    // sequencer
    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        pay_next        = pay_reg;
        count_next      = count_reg;
        front_next      = front_reg;
        rd_pos_next     = rd_pos_reg;
        cmp_valid_next  = 1'b0;
        cmp_pos_next    = cmp_pos_reg;
        left_next       = left_reg;
        wr_pend_next    = 1'b0;
        wr_pos_next     = wr_pos_reg;
        ins_pos_next    = ins_pos_reg;
        res_status_next = res_status_reg;
        res_key_next    = res_key_reg;
        res_pay_next    = res_pay_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = slot_of(count_reg, front_reg);
        ram_wr_data     = {pay_reg, key_reg};
        ram_rd_en       = 1'b0;
        ram_rd_addr     = slot_of(rd_pos_reg, front_reg);

        case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    op_next    = s_tdata[OP_W-1:0];
                    key_next   = s_tdata[OP_W+KEY_W-1:OP_W];
                    pay_next   = s_tdata[S_FIELDS_W-1:OP_W+KEY_W];
                    state_next = ST_START;
                end
            end
            ST_START: begin
                res_status_next = STAT_OK;
                res_key_next    = '0;
                res_pay_next    = '0;
                rd_pos_next     = '0;
                state_next      = ST_DONE;
                case (op_reg)
                    OP_PUSH_BACK: begin
                        if (full) begin
                            res_status_next = STAT_FULL;
                        end else begin
                            ram_wr_en  = 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    OP_POP_BACK, OP_POP_FRONT: begin
                        if (empty) begin
                            res_status_next = STAT_EMPTY;
                        end else begin
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = (op_reg == OP_POP_BACK)
                                ? slot_of(count_reg - 1'b1, front_reg) : front_reg;
                            state_next  = ST_POP;
                        end
                    end
                    OP_DELETE, OP_SEARCH: begin
                        state_next = ST_SCAN;
                    end
                    OP_INSERT: begin
                        if (full) begin
                            res_status_next = STAT_FULL;
                        end else begin
                            state_next = ST_SCAN;
                        end
                    end
                    OP_CLEAR: begin
                        count_next = '0;
                        front_next = '0;
                    end
                    default: begin
                    end
                endcase
            end
            ST_POP: begin
                res_key_next = rd_key;
                res_pay_next = rd_pay;
                count_next   = count_reg - 1'b1;
                if (op_reg == OP_POP_FRONT) begin
                    front_next = (front_reg == AW'(DEPTH - 1)) ? '0 : front_reg + 1'b1;
                end
                state_next = ST_DONE;
            end
            ST_SCAN: begin
                if (hit) begin
                    case (op_reg)
                        OP_SEARCH: begin
                            res_key_next = rd_key;
                            res_pay_next = rd_pay;
                            state_next   = ST_DONE;
                        end
                        OP_DELETE: begin
                            res_key_next = rd_key;
                            res_pay_next = rd_pay;
                            rd_pos_next  = cmp_pos_reg + 1'b1;
                            left_next    = count_reg - cmp_pos_reg - 1'b1;
                            state_next   = ST_SHIFT;
                        end
                        default: begin
                            ins_pos_next = cmp_pos_reg;
                            rd_pos_next  = count_reg - 1'b1;
                            left_next    = count_reg - cmp_pos_reg;
                            state_next   = ST_SHIFT;
                        end
                    endcase
                end else if (rd_pos_reg < count_reg) begin
                    // fetch the next entry, compared in the following cycle
                    ram_rd_en      = 1'b1;
                    cmp_valid_next = 1'b1;
                    cmp_pos_next   = rd_pos_reg;
                    rd_pos_next    = rd_pos_reg + 1'b1;
                end else if (op_reg == OP_INSERT) begin
                    // every key below the new one: append at the back
                    ins_pos_next = count_reg;
                    left_next    = '0;
                    state_next   = ST_SHIFT;
                end else begin
                    res_status_next = STAT_NOT_FOUND;
                    state_next      = ST_DONE;
                end
            end
            ST_SHIFT: begin
                // write back the entry read in the previous cycle
                if (wr_pend_reg) begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = slot_of(wr_pos_reg, front_reg);
                    ram_wr_data = ram_rd_data;
                end
                if (left_reg != '0) begin
                    ram_rd_en    = 1'b1;
                    wr_pend_next = 1'b1;
                    left_next    = left_reg - 1'b1;
                    if (op_reg == OP_DELETE) begin
                        wr_pos_next = rd_pos_reg - 1'b1;
                        rd_pos_next = rd_pos_reg + 1'b1;
                    end else begin
                        wr_pos_next = rd_pos_reg + 1'b1;
                        rd_pos_next = rd_pos_reg - 1'b1;
                    end
                end else if (!wr_pend_reg) begin
                    if (op_reg == OP_DELETE) begin
                        count_next = count_reg - 1'b1;
                    end else begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = slot_of(ins_pos_reg, front_reg);
                        ram_wr_data = {pay_reg, key_reg};
                        count_next  = count_reg + 1'b1;
                    end
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            front_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            wr_pend_reg   <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            front_reg     <= front_next;
            cmp_valid_reg <= cmp_valid_next;
            wr_pend_reg   <= wr_pend_next;
            if (state_reg == ST_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // request, position and result registers
    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        pay_reg        <= pay_next;
        rd_pos_reg     <= rd_pos_next;
        cmp_pos_reg    <= cmp_pos_next;
        left_reg       <= left_next;
        wr_pos_reg     <= wr_pos_next;
        ins_pos_reg    <= ins_pos_next;
        res_status_reg <= res_status_next;
        res_key_reg    <= res_key_next;
        res_pay_reg    <= res_pay_next;
        if (state_reg == ST_DONE && out_free) begin
            m_status_reg <= res_status_reg;
            m_key_reg    <= res_key_reg;
            m_pay_reg    <= res_pay_reg;
            m_count_reg  <= count_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'({m_count_reg, m_pay_reg, m_key_reg, m_status_reg});

    // list never holds more than its depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    // the scan only reads the store
    a_scan_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |-> !ram_wr_en)
        else $error("store written during scan");

    // a refused append or insert reports a full list
    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && m_status_reg == STAT_FULL |-> m_count_reg == CW'(DEPTH))
        else $error("full status with list not full");

    // an empty-list pop reports zero entries and no data
    a_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && m_status_reg == STAT_EMPTY
            |-> m_count_reg == '0 && m_key_reg == '0 && m_pay_reg == '0)
        else $error("empty status with entries or data");

endmodule

`default_nettype wire

>>> tb/kslq_checker.sv
// kslq_checker: watches both stream channels of the keyed stack/queue list,
// keeps its own copy of the list and checks every result transfer in order.
// Depends on kslq_pkg.
`timescale 1ns / 100ps
`default_nettype none

module kslq_checker #(
    parameter int DEPTH = kslq_pkg::DEPTH_DEF,
    localparam int CNT_W = $clog2(DEPTH + 1),
    localparam int RES_W = kslq_pkg::STATUS_W + kslq_pkg::KEY_W + kslq_pkg::PAY_W + CNT_W,
    localparam int M_TDATA_W = ((RES_W + 7) / 8) * 8
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // [2:0] op, [34:3] key, [66:35] payload
    input  wire logic [kslq_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic                           s_tvalid,
    input  wire logic                           s_tready,
    // [1:0] status, [33:2] key_out, [65:34] payload_out, then count
    input  wire logic [M_TDATA_W-1:0]           m_tdata,
    input  wire logic                           m_tvalid,
    input  wire logic                           m_tready,
    output int unsigned                         fail_count,
    output int unsigned                         pending
);

    import kslq_pkg::*;

    // one result transfer, last field in the highest bits
    typedef struct packed {
        logic [CNT_W-1:0]        count;
        logic [PAY_W-1:0]        payload;
        logic signed [KEY_W-1:0] key;
        logic [STATUS_W-1:0]     status;
    } list_result_t;

    // shadow copy of the circular entry store
    logic signed [KEY_W-1:0] keys_q [DEPTH];
    logic [PAY_W-1:0]        pays_q [DEPTH];
    int unsigned             head;
    int unsigned             fill;

    list_result_t pending_responses[$];

    function automatic int unsigned slot(int unsigned pos);
        return (head + pos) % DEPTH;
    endfunction

    // apply one request to the shadow list and build its response
    function automatic list_result_t list_execute(logic [OP_W-1:0] op,
                                                  logic signed [KEY_W-1:0] key,
                                                  logic [PAY_W-1:0] pay);
        list_result_t r;
        int unsigned  pos;
        int unsigned  idx;
        r = '0;
        r.status = STAT_OK;
        case (op)
            OP_PUSH_BACK: begin
                if (fill >= DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    keys_q[slot(fill)] = key;
                    pays_q[slot(fill)] = pay;
                    fill++;
                end
            end
            OP_POP_BACK: begin
                if (fill == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    r.key     = keys_q[slot(fill - 1)];
                    r.payload = pays_q[slot(fill - 1)];
                    fill--;
                end
            end
            OP_POP_FRONT: begin
                if (fill == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    r.key     = keys_q[slot(0)];
                    r.payload = pays_q[slot(0)];
                    head = (head + 1) % DEPTH;
                    fill--;
                end
            end
            OP_DELETE, OP_SEARCH: begin
                // first match from the front
                pos = 0;
                while (pos < fill && keys_q[slot(pos)] != key) pos++;
                if (pos == fill) begin
                    r.status = STAT_NOT_FOUND;
                end else begin
                    r.key     = keys_q[slot(pos)];
                    r.payload = pays_q[slot(pos)];
                    if (op == OP_DELETE) begin
                        // close the gap towards the front
                        while (pos + 1 < fill) begin
                            keys_q[slot(pos)] = keys_q[slot(pos + 1)];
                            pays_q[slot(pos)] = pays_q[slot(pos + 1)];
                            pos++;
                        end
                        fill--;
                    end
                end
            end
            OP_CLEAR: begin
                fill = 0;
                head = 0;
            end
            OP_INSERT: begin
                if (fill >= DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    // equal keys: new entry lands before the first equal one
                    pos = 0;
                    while (pos < fill && key > keys_q[slot(pos)]) pos++;
                    idx = fill;
                    while (idx > pos) begin
                        keys_q[slot(idx)] = keys_q[slot(idx - 1)];
                        pays_q[slot(idx)] = pays_q[slot(idx - 1)];
                        idx--;
                    end
                    keys_q[slot(pos)] = key;
                    pays_q[slot(pos)] = pay;
                    fill++;
                end
            end
            default: ;
        endcase
        r.count = fill[CNT_W-1:0];
        return r;
    endfunction

    task automatic flag_field(string field, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0h actual %0h", $time, field, want, got);
            fail_count++;
        end
    endtask

    // results are checked before the request of the same edge is queued
    always @(posedge aclk) begin
        list_result_t got;
        list_result_t want;
        if (!aresetn) begin
            head = 0;
            fill = 0;
            pending_responses.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = list_result_t'(m_tdata[RES_W-1:0]);
                if (pending_responses.size() == 0) begin
                    $display("%0t: unexpected result transfer: expected none actual %0h",
                             $time, got);
                    fail_count++;
                end else begin
                    want = pending_responses.pop_front();
                    flag_field("status", 64'(want.status), 64'(got.status));
                    flag_field("key_out", 64'(want.key), 64'(got.key));
                    flag_field("payload_out", 64'(want.payload), 64'(got.payload));
                    flag_field("count", 64'(want.count), 64'(got.count));
                end
            end
            if (s_tvalid && s_tready) begin
                pending_responses.push_back(list_execute(s_tdata[OP_W-1:0],
                                                         s_tdata[OP_W+KEY_W-1:OP_W],
                                                         s_tdata[S_FIELDS_W-1:OP_W+KEY_W]));
            end
        end
        pending <= pending_responses.size();
    end

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// tb_top: drives requests into keyed_stack_queue_list_unit, stalls the result
// side and gives the verdict. Depends on kslq_pkg, the block and kslq_checker.
`timescale 1ns / 100ps
`default_nettype none

module tb_top;
    import kslq_pkg::*;

    localparam int DEPTH = DEPTH_DEF;
    localparam int M_W = ((STATUS_W + KEY_W + PAY_W + $clog2(DEPTH + 1) + 7) / 8) * 8;
    localparam logic [OP_W-1:0] OP_NONE = 3'd7;

    localparam int RANDOM_ITEMS = 1925;
    localparam int TAIL_ITEMS   = 200;
    localparam int HOLD_AFTER   = 400;
    localparam int HOLD_CYCLES  = 500;
    // longest quiet stretch of a correct run is the long receiver hold
    localparam int QUIET_LIMIT  = 3000;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tvalid = 1'b0;
    logic                 m_tready = 1'b0;
    bit                   idle_on  = 1'b1;
    wire logic            s_tready;
    wire logic [M_W-1:0]  m_tdata;
    wire logic            m_tvalid;
    int unsigned          fail_count;
    int unsigned          pending;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    keyed_stack_queue_list_unit #(.DEPTH(DEPTH)) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    kslq_checker #(.DEPTH(DEPTH)) u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tdata    (s_tdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .m_tdata    (m_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // one request transfer, with an optional idle burst in front of it
    task automatic send(logic [OP_W-1:0] op, logic [KEY_W-1:0] key, logic [PAY_W-1:0] pay);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_tdata  <= {{(S_TDATA_W - S_FIELDS_W){1'b0}}, pay, key, op};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    // grow phases favour adding entries, shrink phases favour removing them
    function automatic logic [OP_W-1:0] pick_op(bit grow);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (grow) begin
            if (r < 40) return OP_PUSH_BACK;
            if (r < 75) return OP_INSERT;
            if (r < 80) return OP_POP_BACK;
            if (r < 85) return OP_POP_FRONT;
            if (r < 90) return OP_DELETE;
            if (r < 98) return OP_SEARCH;
        end else begin
            if (r < 8)  return OP_PUSH_BACK;
            if (r < 15) return OP_INSERT;
            if (r < 40) return OP_POP_BACK;
            if (r < 65) return OP_POP_FRONT;
            if (r < 85) return OP_DELETE;
            if (r < 98) return OP_SEARCH;
        end
        if (r == 98) return OP_CLEAR;
        return OP_NONE;
    endfunction

    // mostly a small key pool so that search and delete hit often
    function automatic logic [KEY_W-1:0] pick_key();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 7) return $urandom_range(0, 15) - 8;
        if (r == 7) begin
            case ($urandom_range(0, 3))
                0:       return 32'h8000_0000;
                1:       return 32'h7fff_ffff;
                2:       return 32'h0000_0000;
                default: return 32'hffff_ffff;
            endcase
        end
        return $urandom();
    endfunction

    // result side: random stall bursts and one long hold-off
    initial begin : result_sink
        int unsigned taken;
        bit          held;
        taken = 0;
        held  = 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (!held && taken >= HOLD_AFTER) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            if (m_tvalid) taken++;
        end
    end

    // ends the run when no transfer happens for too long
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
            else quiet++;
        end
        $display("** keyed_stack_queue_list_unit: FAILED **");
        $finish;
    end

    initial begin : stimulus
        int unsigned     sent;
        logic [OP_W-1:0] op;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty list: every removal and lookup is refused
        send(OP_POP_BACK, 32'd0, 32'd0);
        send(OP_POP_FRONT, 32'd0, 32'd0);
        send(OP_DELETE, 32'd5, 32'd0);
        send(OP_SEARCH, 32'd5, 32'd0);
        send(OP_NONE, 32'hffff_ffff, 32'hffff_ffff);
        // key and payload extremes, sorted insert at front, middle, equal key
        send(OP_PUSH_BACK, 32'h7fff_ffff, 32'h0000_0000);
        send(OP_PUSH_BACK, 32'h8000_0000, 32'hffff_ffff);
        send(OP_INSERT, 32'h0000_0000, 32'ha5a5_5a5a);
        send(OP_INSERT, 32'h7fff_ffff, 32'h0000_0001);
        send(OP_INSERT, 32'h8000_0000, 32'h5a5a_a5a5);
        send(OP_SEARCH, 32'h8000_0000, 32'd0);
        send(OP_SEARCH, 32'd12345, 32'd0);
        send(OP_DELETE, 32'h7fff_ffff, 32'd0);
        send(OP_POP_FRONT, 32'd0, 32'd0);
        send(OP_POP_BACK, 32'd0, 32'd0);
        send(OP_DELETE, 32'hffff_ffff, 32'd0);
        send(OP_CLEAR, 32'd0, 32'd0);
        // removing the only entry in each of the three ways
        send(OP_PUSH_BACK, 32'd7, 32'h1234_5678);
        send(OP_DELETE, 32'd7, 32'd0);
        send(OP_PUSH_BACK, 32'd9, 32'h8765_4321);
        send(OP_POP_FRONT, 32'd0, 32'd0);
        send(OP_INSERT, 32'hffff_fffd, 32'hdead_beef);
        send(OP_POP_BACK, 32'd0, 32'd0);
        send(OP_POP_BACK, 32'd0, 32'd0);

        // random traffic in alternating grow and shrink phases
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if (sent + TAIL_ITEMS >= RANDOM_ITEMS) idle_on <= 1'b0;
            else if ($urandom_range(0, 59) == 0) idle_on <= ($urandom_range(0, 2) != 0);
            op = pick_op(((sent / 150) % 2) == 0);
            send(op, pick_key(), $urandom());
            if (op != OP_NONE) sent++;
        end
        s_tvalid <= 1'b0;
        // let the checker count the last request before draining
        @(posedge aclk);

        // drain, then leave room for a stray late result
        while (pending != 0) @(posedge aclk);
        repeat (DEPTH + 10) @(posedge aclk);
        if (fail_count == 0) begin
            $display("** keyed_stack_queue_list_unit: PASSED **");
        end else begin
            $display("** keyed_stack_queue_list_unit: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire
